// File: rtl/hrf_pkg.sv
// Shared types and constants for the HTTP response framer.
`timescale 1ns / 1ps

package hrf_pkg;

   // Ring size for the byte position within the current section.
   localparam int HISTORY_SIZE = 512;
   localparam int POS_W        = $clog2(HISTORY_SIZE);
   // Width that holds both position plus one and the 16-bit length.
   localparam int CMP_W        = 17;
   localparam int LEN_W        = 16;

   localparam logic [31:0] TAG_HTTP   = 32'h4854_5450;
   localparam logic [63:0] TAG_LENGTH = 64'h4C65_6E67_7468_3A20;
   localparam logic [23:0] TAG_EOH    = 24'h0A_0D0A;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_TWO   = 8'h32;
   localparam logic [7:0] CH_BRACE = 8'h7D;
   localparam logic [7:0] CH_P     = 8'h50;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_HTTP     = 3'd1,
      EV_STAT_OK  = 3'd2,
      EV_STAT_BAD = 3'd3,
      EV_HDR_DONE = 3'd4,
      EV_BODY_OK  = 3'd5,
      EV_MISMATCH = 3'd6
   } event_type;

   typedef enum logic [4:0] {
      PH_IDLE    = 5'b00001,
      PH_STATUS  = 5'b00010,
      PH_HEADERS = 5'b00100,
      PH_LENGTH  = 5'b01000,
      PH_BODY    = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0]       body_byte;
      logic             body_valid;
      event_type        event_res;
      logic [LEN_W-1:0] content_length;
   } result_type;

endpackage

// File: rtl/hrf_parser.sv
// Parser state and the per-byte decision logic of the HTTP response framer.
`timescale 1ns / 1ps

module hrf_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         rx_byte,
   output hrf_pkg::result_type result
);
   import hrf_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [63:0]      hist_ff, hist_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0] accum_ff, accum_in;
   logic             open_ff, open_in;

   logic             http;
   logic             known_phase;
   logic [19:0]      product;
   logic [CMP_W-1:0] pos_plus;
   logic [POS_W-1:0] pos_next;
   event_type        ev;
   logic             body_valid;

   always_comb begin
      hist_in     = {hist_ff[55:0], rx_byte};
      http        = (hist_in[31:0] == TAG_HTTP);
      known_phase = (phase_ff == PH_STATUS) || (phase_ff == PH_HEADERS) ||
                    (phase_ff == PH_LENGTH) || (phase_ff == PH_BODY);
      // Times ten as two shifted copies, plus the new digit.
      product     = {1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0} +
                    {16'd0, rx_byte[3:0]};
      pos_plus    = CMP_W'(pos_ff) + CMP_W'(1);
      pos_next    = (pos_ff == POS_W'(HISTORY_SIZE - 1)) ? '0 : pos_plus[POS_W-1:0];

      phase_in   = phase_ff;
      pos_in     = pos_next;
      accum_in   = accum_ff;
      open_in    = open_ff;
      ev         = EV_NONE;
      body_valid = 1'b0;

      if (known_phase && http) begin
         phase_in = PH_STATUS;
         open_in  = 1'b0;
         pos_in   = '0;
         ev       = EV_HTTP;
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               if (http) begin
                  phase_in = PH_STATUS;
                  pos_in   = '0;
                  ev       = EV_HTTP;
               end
            end
            PH_STATUS: begin
               if (pos_ff == POS_W'(7)) begin
                  if (hist_in[23:16] == CH_TWO && hist_in[15:8] == CH_ZERO) begin
                     phase_in = PH_HEADERS;
                     pos_in   = '0;
                     ev       = EV_STAT_OK;
                  end else begin
                     phase_in = PH_IDLE;
                     ev       = EV_STAT_BAD;
                  end
               end
            end
            PH_HEADERS: begin
               if (pos_ff > POS_W'(16) && hist_in == TAG_LENGTH) begin
                  phase_in = PH_LENGTH;
                  accum_in = '0;
                  open_in  = 1'b1;
               end
            end
            PH_LENGTH: begin
               if (open_ff) begin
                  if (rx_byte == CH_CR) begin
                     open_in = 1'b0;
                  end else if (rx_byte >= CH_ZERO && rx_byte <= CH_NINE) begin
                     accum_in = (product > 20'd65535) ? '1 : product[LEN_W-1:0];
                  end
               end
               if (hist_in[23:0] == TAG_EOH) begin
                  phase_in = PH_BODY;
                  open_in  = 1'b0;
                  pos_in   = '0;
                  ev       = EV_HDR_DONE;
               end
            end
            PH_BODY: begin
               body_valid = 1'b1;
               if (rx_byte == CH_BRACE) begin
                  ev       = (pos_plus == CMP_W'(accum_ff)) ? EV_BODY_OK : EV_MISMATCH;
                  phase_in = PH_IDLE;
               end
            end
            default: begin
            end
         endcase
      end

      result.body_byte      = rx_byte;
      result.body_valid     = body_valid;
      result.event_res      = ev;
      result.content_length = accum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         hist_ff  <= '0;
         pos_ff   <= '0;
         accum_ff <= '0;
         open_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         hist_ff  <= hist_in;
         pos_ff   <= pos_in;
         accum_ff <= accum_in;
         open_ff  <= open_in;
      end
   end

endmodule

// File: rtl/http_response_framer.sv
// Top level of the HTTP response framer: parser plus output register and skid stage.
`timescale 1ns / 1ps

// Usage: feed the received response stream one byte per transfer on the req_
// channel. Every accepted byte gives exactly one transfer on the rsp_ channel,
// in order: the byte itself, a body flag, an event code and the content
// length parsed so far.
// rsp_valid rises at the accepting edge when the output register is free, and
// throughput is one byte per cycle while req_stall is low. The parser state
// updates on acceptance; the per-byte path is a few compares and a times-ten add.
// When the receiver stalls, the result stays in the output register and the
// next byte is still taken into a one-entry skid stage; req_stall rises only
// once that skid stage is full, and falls when the skid entry moves to the output.
// Reset is synchronous and active high: the parser returns to waiting for
// "HTTP", the byte history, position and length clear, and both output
// stages empty. No clearing pass is needed.
module http_response_framer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_rx_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_body_byte,
   output logic                       rsp_body_valid,
   output logic [2:0]                 rsp_event_res,
   output logic [hrf_pkg::LEN_W-1:0]  rsp_content_length
);
   import hrf_pkg::*;

   result_type result;
   result_type out_ff, skid_ff;
   logic       out_valid_ff, skid_valid_ff;
   logic       accept, out_free;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;

   hrf_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_valid_ff ? skid_ff : result;
      end
      if (!out_free && accept) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_body_byte      = out_ff.body_byte;
   assign rsp_body_valid     = out_ff.body_valid;
   assign rsp_event_res      = out_ff.event_res;
   assign rsp_content_length = out_ff.content_length;

endmodule

// File: rtl/hrf_checker.sv
// Port-level checks for the HTTP response framer, bound to the top level.
`timescale 1ns / 1ps

module hrf_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [7:0]                rsp_body_byte,
   input logic                      rsp_body_valid,
   input logic [2:0]                rsp_event_res,
   input logic [hrf_pkg::LEN_W-1:0] rsp_content_length
);
   import hrf_pkg::*;

   // A body byte never carries a status or restart event.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_body_valid |->
         rsp_event_res == EV_NONE || rsp_event_res == EV_BODY_OK ||
         rsp_event_res == EV_MISMATCH)
      else $error("body byte with a non-body event");

   // The end of the body is always a closing brace inside the body.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EV_BODY_OK || rsp_event_res == EV_MISMATCH) |->
         rsp_body_byte == CH_BRACE && rsp_body_valid)
      else $error("end of body not on a closing brace");

   // A restart is only reported on the byte that completes the tag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_HTTP |-> rsp_body_byte == CH_P && !rsp_body_valid)
      else $error("restart event on the wrong byte");

   // The end of the headers falls on a line feed that is not body.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_HDR_DONE |-> rsp_body_byte == CH_LF && !rsp_body_valid)
      else $error("end of headers on the wrong byte");

   // A stalled result holds until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_body_byte) &&
         $stable(rsp_event_res) && $stable(rsp_content_length))
      else $error("stalled result changed");

endmodule

bind http_response_framer hrf_checker u_checker (.*);
